// File: design/alu32_pkg.sv
package alu32_pkg;

  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,
    OP_ADDC = 5'd1,
    OP_SUB  = 5'd2,
    OP_SUBC = 5'd3,
    OP_MUL  = 5'd4,
    OP_UMUL = 5'd5,
    OP_DIV  = 5'd6,
    OP_UDIV = 5'd7,
    OP_REM  = 5'd8,
    OP_UREM = 5'd9,
    OP_AND  = 5'd10,
    OP_OR   = 5'd11,
    OP_XOR  = 5'd12,
    OP_SHL  = 5'd13,
    OP_SHR  = 5'd14,
    OP_SAR  = 5'd15,
    OP_NOT  = 5'd16
  } opcode_t;

  localparam logic [2:0] CC_ALWAYS = 3'd0;
  localparam logic [2:0] CC_EQ     = 3'd1;
  localparam logic [2:0] CC_NE     = 3'd2;
  localparam logic [2:0] CC_LT     = 3'd3;
  localparam logic [2:0] CC_GT     = 3'd4;
  localparam logic [2:0] CC_LE     = 3'd5;
  localparam logic [2:0] CC_GE     = 3'd6;

  localparam int unsigned CC_UNSIGNED_BIT = 3;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [31:0] INT_MIN  = 32'h8000_0000;

  typedef struct packed {
    logic [4:0]  opcode;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic [3:0]  cond;
  } alu_in_t;

  typedef struct packed {
    logic [31:0] result;
    logic        bad_opcode;
    logic        carry_out;
    logic        zero_out;
    logic        negative_out;
    logic        cond_true;
  } alu_out_t;

  // Iterative unit command and status
  typedef struct packed {
    logic        start;
    logic        is_mul;
    logic [31:0] op_a;
    logic [31:0] op_b;
  } iter_cmd_t;

  typedef struct packed {
    logic        done;
    logic [31:0] lo;
    logic [31:0] hi;
  } iter_sts_t;

endpackage

// File: design/alu32_with_flags_and_conditions.sv
// Channel | direction | payload   | handshake
// in      | input     | alu_in_t  | in_valid / in_ready
// out     | output    | alu_out_t | out_valid / out_ready
//
// Add, sub, logic, shift, not and unknown codes: the execute state registers the result.
// Mul, umul, div, udiv, rem and urem: the execute state loads the shared
// shift-add/subtract unit, which runs 32 steps, and the iterate state then
// applies the sign and registers the result.
// One item at a time; in_ready is low from acceptance until the result is taken.
// rst (synchronous) clears flags to 0 and empties the block.
module alu32_with_flags_and_conditions
  import alu32_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  alu_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output alu_out_t out_data
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_ITER = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state;
  alu_in_t item;
  logic carry_flag, zero_flag, negative_flag;
  logic ct;
  logic neg_res, a_neg, b_neg;
  logic [31:0] mag_a, mag_b;
  iter_cmd_t cmd;
  iter_sts_t sts;

  logic [31:0] r;
  logic        bad, c_next, upd;
  logic [32:0] wide;
  logic [4:0]  sh;
  logic        special;
  logic [31:0] special_val;
  logic [31:0] div_pick;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  // Condition test on the flags held at acceptance
  function automatic logic cond_eval(logic [3:0] c, logic cf, logic zf, logic nf);
    logic lt;
    lt = c[CC_UNSIGNED_BIT] ? cf : nf;
    case (c[2:0])
      CC_ALWAYS: return 1'b1;
      CC_EQ:     return zf;
      CC_NE:     return ~zf;
      CC_LT:     return lt;
      CC_GT:     return ~lt & ~zf;
      CC_LE:     return lt | zf;
      CC_GE:     return ~lt;
      default:   return 1'b0;
    endcase
  endfunction

  assign a_neg = item.operand_a[31];
  assign b_neg = item.operand_b[31];
  assign mag_a = a_neg ? (~item.operand_a + 32'd1) : item.operand_a;
  assign mag_b = b_neg ? (~item.operand_b + 32'd1) : item.operand_b;

  // Load the shared unit
  always_comb begin
    cmd.start  = (state == S_EXEC) &&
                 (item.opcode >= OP_MUL) && (item.opcode <= OP_UREM);
    cmd.is_mul = (item.opcode == OP_MUL) || (item.opcode == OP_UMUL);
    cmd.op_a   = item.operand_a;
    cmd.op_b   = item.operand_b;
    if (item.opcode == OP_DIV || item.opcode == OP_REM) begin
      cmd.op_a = mag_a;
      cmd.op_b = mag_b;
    end
  end

  alu32_iter u_iter (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .sts (sts)
  );

  // Division corner cases
  always_comb begin
    special     = 1'b0;
    special_val = '0;
    if (item.operand_b == '0) begin
      special     = 1'b1;
      special_val = (item.opcode == OP_DIV || item.opcode == OP_UDIV) ?
                    ALL_ONES : item.operand_a;
    end else if (item.operand_a == INT_MIN && item.operand_b == ALL_ONES &&
                 (item.opcode == OP_DIV || item.opcode == OP_REM)) begin
      special     = 1'b1;
      special_val = (item.opcode == OP_DIV) ? INT_MIN : 32'd0;
    end
  end

  // Operations that do not use the shared unit
  always_comb begin
    r      = '0;
    bad    = 1'b0;
    c_next = carry_flag;
    upd    = 1'b0;
    wide   = '0;
    sh     = item.operand_b[4:0];
    case (item.opcode)
      OP_ADD, OP_ADDC: begin
        wide = {1'b0, item.operand_a} + {1'b0, item.operand_b} +
               {32'd0, (item.opcode == OP_ADDC) & carry_flag};
        r = wide[31:0]; c_next = wide[32]; upd = 1'b1;
      end
      OP_SUB, OP_SUBC: begin
        wide = {1'b0, item.operand_a} - {1'b0, item.operand_b} -
               {32'd0, (item.opcode == OP_SUBC) & carry_flag};
        r = wide[31:0]; c_next = wide[32]; upd = 1'b1;
      end
      OP_AND: r = item.operand_a & item.operand_b;
      OP_OR:  r = item.operand_a | item.operand_b;
      OP_XOR: r = item.operand_a ^ item.operand_b;
      OP_SHL: r = item.operand_a << sh;
      OP_SHR: r = item.operand_a >> sh;
      OP_SAR: r = $unsigned($signed(item.operand_a) >>> sh);
      OP_NOT: r = ~item.operand_a;
      OP_MUL, OP_UMUL, OP_DIV, OP_UDIV, OP_REM, OP_UREM: r = '0;
      default: bad = 1'b1;
    endcase
  end

  // Sign of the finished quotient or remainder
  assign neg_res = (item.opcode == OP_DIV) ? (a_neg ^ b_neg) :
                   (item.opcode == OP_REM) ? a_neg : 1'b0;

  // Pick quotient or remainder from the shared unit
  assign div_pick = (item.opcode == OP_DIV || item.opcode == OP_UDIV) ? sts.lo : sts.hi;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      carry_flag    <= 1'b0;
      zero_flag     <= 1'b0;
      negative_flag <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item  <= in_data;
            ct    <= cond_eval(in_data.cond, carry_flag, zero_flag, negative_flag);
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (cmd.start) begin
            state <= S_ITER;
          end else begin
            if (upd) begin
              carry_flag    <= c_next;
              zero_flag     <= (r == '0);
              negative_flag <= r[31];
            end
            out_data.result     <= r;
            out_data.bad_opcode <= bad;
            out_data.carry_out  <= upd ? c_next : carry_flag;
            out_data.zero_out   <= upd ? (r == '0) : zero_flag;
            out_data.negative_out <= upd ? r[31] : negative_flag;
            out_data.cond_true  <= ct;
            state <= S_OUT;
          end
        end
        S_ITER: begin
          if (sts.done) begin
            if (cmd.is_mul) begin
              out_data.result <= sts.lo;
            end else if (special) begin
              out_data.result <= special_val;
            end else begin
              out_data.result <= neg_res ? (~div_pick + 32'd1) : div_pick;
            end
            out_data.bad_opcode   <= 1'b0;
            out_data.carry_out    <= carry_flag;
            out_data.zero_out     <= zero_flag;
            out_data.negative_out <= negative_flag;
            out_data.cond_true    <= ct;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // Flags move only when an add or subtract finishes
  a_flags_hold: assert property (@(posedge clk) disable iff (rst)
    (state != S_EXEC) |=> $stable({carry_flag, zero_flag, negative_flag}))
    else $error("flags changed outside execute");
  // Unknown opcode always reports zero result
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.bad_opcode) |-> (out_data.result == '0))
    else $error("bad opcode with nonzero result");
  // Shared unit finishes only while waiting on it
  a_done_iter: assert property (@(posedge clk) disable iff (rst)
    sts.done |-> (state == S_ITER))
    else $error("iterative unit done outside iterate state");
`endif

endmodule

// File: design/alu32_iter.sv
// Shared shift-add/shift-subtract unit: 32 steps of multiply or restoring divide.
// lo returns product or quotient, hi returns remainder.
module alu32_iter
  import alu32_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  iter_cmd_t cmd,
  output iter_sts_t sts
);

  logic [31:0] acc;
  logic [31:0] shreg;
  logic [31:0] opb;
  logic        mul;
  logic [5:0]  count;
  logic        busy;
  logic        done;

  // Partial remainder keeps its top bit while shifting, so the trial is 34 bits
  logic [33:0] trial;
  logic [32:0] rem_shift;

  // One step of the shared subtractor
  always_comb begin
    rem_shift = {acc, shreg[31]};
    trial     = {1'b0, rem_shift} - {2'b00, opb};
  end

  // Advance the sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy  <= 1'b1;
        count <= 6'd0;
      end else if (busy) begin
        count <= count + 6'd1;
        if (count == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc   <= '0;
      shreg <= cmd.op_a;
      opb   <= cmd.op_b;
      mul   <= cmd.is_mul;
    end else if (busy) begin
      if (mul) begin
        // low product: acc = acc*2 + a_bit*b, MSB first
        acc   <= {acc[30:0], 1'b0} + (shreg[31] ? opb : 32'd0);
        shreg <= {shreg[30:0], 1'b0};
      end else begin
        if (!trial[33]) begin
          acc <= trial[31:0];
        end else begin
          acc <= rem_shift[31:0];
        end
        shreg <= {shreg[30:0], ~trial[33]};
      end
    end
  end

  assign sts.done = done;
  assign sts.lo   = mul ? acc : shreg;
  assign sts.hi   = acc;

endmodule

// File: sim/tb_alu32_with_flags_and_conditions.sv
module tb_alu32_with_flags_and_conditions;
  import alu32_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Flag model and queue of pending ALU results
  class alu_scoreboard;
    logic carry_q, zero_q, neg_q;
    alu_out_t pending_q[$];
    int errors;
    int checked;

    function void clear_flags();
      carry_q = 1'b0;
      zero_q = 1'b0;
      neg_q = 1'b0;
    endfunction

    function logic eval_cond(logic [3:0] cc);
      logic lt;
      lt = cc[CC_UNSIGNED_BIT] ? carry_q : neg_q;
      case (cc[2:0])
        CC_ALWAYS: return 1'b1;
        CC_EQ:     return zero_q;
        CC_NE:     return !zero_q;
        CC_LT:     return lt;
        CC_GT:     return !lt && !zero_q;
        CC_LE:     return lt || zero_q;
        CC_GE:     return !lt;
        default:   return 1'b0;
      endcase
    endfunction

    // Predict the result of one accepted transaction and advance the flags
    function void note_input(alu_in_t t);
      alu_out_t e;
      logic [32:0] wide;
      logic [32:0] subtrahend;
      logic [31:0] a, b, ma, mb, q;
      logic [4:0] sh;
      a = t.operand_a;
      b = t.operand_b;
      sh = b[4:0];
      e = '0;
      e.cond_true = eval_cond(t.cond);
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      case (t.opcode)
        OP_ADD, OP_ADDC: begin
          wide = {1'b0, a} + {1'b0, b} + ((t.opcode == OP_ADDC) ? carry_q : 1'b0);
          e.result = wide[31:0];
          carry_q = wide[32];
        end
        OP_SUB, OP_SUBC: begin
          subtrahend = {1'b0, b} + ((t.opcode == OP_SUBC) ? carry_q : 1'b0);
          e.result = a - subtrahend[31:0];
          carry_q = ({1'b0, a} < subtrahend);
        end
        OP_MUL, OP_UMUL: e.result = a * b;
        OP_DIV: begin
          if (b == 0) e.result = ALL_ONES;
          else if (a == INT_MIN && b == ALL_ONES) e.result = INT_MIN;
          else begin
            q = ma / mb;
            e.result = (a[31] ^ b[31]) ? -q : q;
          end
        end
        OP_UDIV: e.result = (b == 0) ? ALL_ONES : a / b;
        OP_REM: begin
          if (b == 0) e.result = a;
          else if (a == INT_MIN && b == ALL_ONES) e.result = '0;
          else begin
            q = ma % mb;
            e.result = a[31] ? -q : q;
          end
        end
        OP_UREM: e.result = (b == 0) ? a : a % b;
        OP_AND:  e.result = a & b;
        OP_OR:   e.result = a | b;
        OP_XOR:  e.result = a ^ b;
        OP_SHL:  e.result = a << sh;
        OP_SHR:  e.result = a >> sh;
        OP_SAR:  e.result = $signed(a) >>> sh;
        OP_NOT:  e.result = ~a;
        default: e.bad_opcode = 1'b1;
      endcase
      if (t.opcode inside {OP_ADD, OP_ADDC, OP_SUB, OP_SUBC}) begin
        zero_q = (e.result == 0);
        neg_q = e.result[31];
      end
      e.carry_out = carry_q;
      e.zero_out = zero_q;
      e.negative_out = neg_q;
      pending_q.push_back(e);
    endfunction

    // Compare one accepted result with the oldest prediction
    function void check_result(alu_out_t got);
      alu_out_t e;
      checked++;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result %h", got);
        return;
      end
      e = pending_q.pop_front();
      if (got.result !== e.result || got.bad_opcode !== e.bad_opcode ||
          got.carry_out !== e.carry_out || got.zero_out !== e.zero_out ||
          got.negative_out !== e.negative_out || got.cond_true !== e.cond_true) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: result %0d: expected r=%h bad=%b c=%b z=%b n=%b ct=%b,",
                   checked, e.result, e.bad_opcode, e.carry_out, e.zero_out,
                   e.negative_out, e.cond_true);
          $display("       got r=%h bad=%b c=%b z=%b n=%b ct=%b",
                   got.result, got.bad_opcode, got.carry_out, got.zero_out,
                   got.negative_out, got.cond_true);
        end
      end
    endfunction
  endclass

  localparam int STALL_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  alu_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  alu_out_t out_data;

  alu_scoreboard sb = new();
  bit calm_mode = 1'b0;
  bit timed_out = 1'b0;
  int sent = 0;
  int idle_cycles = 0;

  alu32_with_flags_and_conditions DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Random receiver stall, off during the calm stretch
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= calm_mode ? 1'b1 : ($urandom_range(99) >= 33);
  end

  // Check results and watch for a hung block
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT && !timed_out) begin
        timed_out = 1'b1;
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Present one transaction and hold it until accepted; valid stays up afterward
  task automatic send_op(logic [4:0] op, logic [31:0] a, logic [31:0] b, logic [3:0] cc);
    alu_in_t t;
    t.opcode = op;
    t.operand_a = a;
    t.operand_b = b;
    t.cond = cc;
    while (!calm_mode && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (!in_ready);
    sb.note_input(t);
    sent++;
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(7))
      0: return 32'h0;
      1: return ALL_ONES;
      2: return INT_MIN;
      3: return 32'h7FFF_FFFF;
      4: return $urandom_range(40);
      5: return -$urandom_range(40);
      default: return $urandom;
    endcase
  endfunction

  // Drop valid and wait until every expected result has come
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [4:0] op;
    sb.clear_flags();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners
    send_op(OP_ADD, ALL_ONES, 32'h1, {1'b1, CC_EQ});
    send_op(OP_ADDC, 32'h0, 32'h0, {1'b1, CC_LT});
    send_op(OP_SUB, 32'h0, 32'h1, {1'b0, CC_GT});
    send_op(OP_SUBC, 32'h5, 32'h4, {1'b1, CC_LE});
    send_op(OP_SUB, INT_MIN, 32'h1, {1'b0, CC_GE});
    send_op(OP_MUL, ALL_ONES, ALL_ONES, {1'b0, CC_NE});
    send_op(OP_UMUL, 32'h1234_5678, 32'h9ABC_DEF0, 4'd7);
    send_op(OP_DIV, 32'd7, 32'h0, {1'b0, CC_ALWAYS});
    send_op(OP_DIV, INT_MIN, ALL_ONES, {1'b0, CC_LT});
    send_op(OP_DIV, -32'sd7, 32'd2, 4'd15);
    send_op(OP_UDIV, ALL_ONES, 32'h0, {1'b1, CC_GE});
    send_op(OP_REM, INT_MIN, ALL_ONES, {1'b0, CC_EQ});
    send_op(OP_REM, -32'sd7, 32'd2, {1'b1, CC_NE});
    send_op(OP_REM, 32'd9, 32'h0, {1'b0, CC_LE});
    send_op(OP_UREM, ALL_ONES, 32'd10, {1'b1, CC_GT});
    send_op(OP_UREM, 32'd5, 32'h0, {1'b0, CC_ALWAYS});
    send_op(OP_AND, ALL_ONES, 32'h0F0F_0F0F, {1'b1, CC_LT});
    send_op(OP_OR, 32'h0, INT_MIN, {1'b0, CC_LT});
    send_op(OP_XOR, ALL_ONES, ALL_ONES, {1'b0, CC_EQ});
    send_op(OP_SHL, ALL_ONES, 32'd33, {1'b0, CC_NE});
    send_op(OP_SHR, INT_MIN, 32'd31, {1'b1, CC_GE});
    send_op(OP_SAR, INT_MIN, 32'hFFFF_FFE0, {1'b0, CC_GT});
    send_op(OP_SAR, INT_MIN, 32'd31, {1'b0, CC_LE});
    send_op(OP_NOT, 32'h0, 32'h0, {1'b1, CC_ALWAYS});
    send_op(5'd31, ALL_ONES, ALL_ONES, 4'd7);

    // Let everything drain before the random part
    drain_results();

    // Random mix, flag-setting ops weighted up so conditions see varied flags
    for (int i = 0; i < 900; i++) begin
      calm_mode = (i >= 300 && i < 400);
      case ($urandom_range(9))
        0, 1, 2: op = 5'($urandom_range(OP_SUBC));
        3:       op = 5'($urandom_range(31));
        default: op = 5'($urandom_range(OP_NOT));
      endcase
      send_op(op, pick_operand(), pick_operand(), 4'($urandom_range(15)));
    end
    calm_mode = 1'b0;

    drain_results();
    repeat (50) @(posedge clk);
    $display("Sent %0d transactions, checked %0d results: all opcodes incl. unknown,", sent,
             sb.checked);
    $display("every condition code, divide and shift corners, with random stalls.");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
